// ----- rtl/core/bsa_pkg.sv -----
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_KIND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET = 3'd4;

  localparam logic [1:0] KIND_VARIABLE = 2'd1;
  localparam logic [1:0] KIND_ENCODED = 2'd2;

  localparam logic [3:0] F_ALLOC_FREE = 4'd0;
  localparam logic [3:0] F_ALLOC_AT = 4'd1;
  localparam logic [3:0] F_RELEASE = 4'd2;
  localparam logic [3:0] F_RELEASE_BYTE = 4'd3;
  localparam logic [3:0] F_SET_VER = 4'd4;
  localparam logic [3:0] F_CLR_VER = 4'd5;
  localparam logic [3:0] F_SET_FULL = 4'd6;
  localparam logic [3:0] F_CLR_FULL = 4'd7;
  localparam logic [3:0] F_LAST = 4'd8;
  localparam logic [3:0] F_CLEAR = 4'd9;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_USED = 3'd2;
  localparam logic [2:0] ST_NOT_USED = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] position;
    logic        transactional;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot_index;
    logic [63:0] logical_address;
    logic [27:0] slot_byte_offset;
    logic        full_seen;
    logic [12:0] last_slot;
    logic [12:0] used_count;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_DIV, S_POSTDIV, S_READ, S_RWAIT, S_FS_RD, S_FS_CHK,
    S_FS_BIT, S_MUL, S_ADDR, S_L_INIT, S_L_RD, S_L_CHK, S_L_BIT, S_DONE
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START, OP_DIV, OP_POSTDIV, OP_READ, OP_RWAIT,
    OP_FS_RD, OP_FS_CHK, OP_FS_BIT, OP_MUL, OP_ADDR, OP_L_INIT, OP_L_RD,
    OP_L_CHK, OP_L_BIT, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic start_done;
    logic start_div;
    logic start_scan;
    logic div_last;
    logic div_range;
    logic alloc_ok;
    logic wd_hit;
    logic wd_end;
    logic grp_hit;
    logic slot_over;
  } dp_stat_t;

endpackage

// ----- rtl/core/bitmap_slot_allocator.sv -----
`timescale 1ns / 1ps

// Slot allocator for one page, holding a used bitmap and a version bitmap.
// A request enters on in_valid/in_stall (in_data: func, position,
// transactional) and yields exactly one result on out_valid/out_stall.
// The cfg port writes a register at any edge with cfg_we high; write it
// only while no request is in flight.
// Each request runs alone. Decode comes first, a byte release adds a
// 16-bit divider, a free slot search reads one bitmap word at a time
// plus up to eight bit group steps, and allocation adds one step each
// for the multiply and the address add. Every request ends with a
// descending scan for the last used slot, one word at a time plus up to
// eight steps.
// Reset empties both bitmaps at once through per-word valid bits and
// restores the register defaults. The result waits in an output register
// while the receiver stalls; the next request is taken meanwhile and holds
// at its end until that register is free.
module bitmap_slot_allocator #(
  parameter int MAP_WORDS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bsa_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bsa_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data
);

  bsa_pkg::dp_op_t   op;
  bsa_pkg::dp_stat_t stat;

  bsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .op(op), .stat(stat)
  );

  bsa_dp #(.MAP_WORDS(MAP_WORDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .stat(stat), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .out_data(out_data)
  );

endmodule

// ----- rtl/core/bsa_ram.sv -----
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bsa_ctrl.sv -----
`timescale 1ns / 1ps

module bsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output bsa_pkg::dp_op_t    op,
  input  bsa_pkg::dp_stat_t  stat
);

  bsa_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != bsa_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsa_pkg::S_IDLE: if (in_valid) state_nxt = bsa_pkg::S_START;
      bsa_pkg::S_START: begin
        if (stat.start_done) state_nxt = bsa_pkg::S_L_INIT;
        else if (stat.start_div) state_nxt = bsa_pkg::S_DIV;
        else if (stat.start_scan) state_nxt = bsa_pkg::S_FS_RD;
        else state_nxt = bsa_pkg::S_READ;
      end
      bsa_pkg::S_DIV: if (stat.div_last) state_nxt = bsa_pkg::S_POSTDIV;
      bsa_pkg::S_POSTDIV: begin
        state_nxt = stat.div_range ? bsa_pkg::S_L_INIT : bsa_pkg::S_READ;
      end
      bsa_pkg::S_READ: state_nxt = bsa_pkg::S_RWAIT;
      bsa_pkg::S_RWAIT: state_nxt = stat.alloc_ok ? bsa_pkg::S_MUL : bsa_pkg::S_L_INIT;
      bsa_pkg::S_FS_RD: state_nxt = bsa_pkg::S_FS_CHK;
      bsa_pkg::S_FS_CHK: begin
        if (stat.wd_hit) state_nxt = bsa_pkg::S_FS_BIT;
        else if (stat.wd_end) state_nxt = bsa_pkg::S_L_INIT;
        else state_nxt = bsa_pkg::S_FS_RD;
      end
      bsa_pkg::S_FS_BIT: begin
        if (stat.grp_hit) begin
          state_nxt = stat.slot_over ? bsa_pkg::S_L_INIT : bsa_pkg::S_READ;
        end
      end
      bsa_pkg::S_MUL: state_nxt = bsa_pkg::S_ADDR;
      bsa_pkg::S_ADDR: state_nxt = bsa_pkg::S_L_INIT;
      bsa_pkg::S_L_INIT: state_nxt = bsa_pkg::S_L_RD;
      bsa_pkg::S_L_RD: state_nxt = bsa_pkg::S_L_CHK;
      bsa_pkg::S_L_CHK: begin
        if (stat.wd_hit) state_nxt = bsa_pkg::S_L_BIT;
        else if (stat.wd_end) state_nxt = bsa_pkg::S_DONE;
        else state_nxt = bsa_pkg::S_L_RD;
      end
      bsa_pkg::S_L_BIT: if (stat.grp_hit) state_nxt = bsa_pkg::S_DONE;
      bsa_pkg::S_DONE: if (out_free) state_nxt = bsa_pkg::S_IDLE;
      default: state_nxt = bsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op = bsa_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      bsa_pkg::S_IDLE: if (in_valid) op = bsa_pkg::OP_LOAD;
      bsa_pkg::S_START: op = bsa_pkg::OP_START;
      bsa_pkg::S_DIV: op = bsa_pkg::OP_DIV;
      bsa_pkg::S_POSTDIV: op = bsa_pkg::OP_POSTDIV;
      bsa_pkg::S_READ: op = bsa_pkg::OP_READ;
      bsa_pkg::S_RWAIT: op = bsa_pkg::OP_RWAIT;
      bsa_pkg::S_FS_RD: op = bsa_pkg::OP_FS_RD;
      bsa_pkg::S_FS_CHK: op = bsa_pkg::OP_FS_CHK;
      bsa_pkg::S_FS_BIT: op = bsa_pkg::OP_FS_BIT;
      bsa_pkg::S_MUL: op = bsa_pkg::OP_MUL;
      bsa_pkg::S_ADDR: op = bsa_pkg::OP_ADDR;
      bsa_pkg::S_L_INIT: op = bsa_pkg::OP_L_INIT;
      bsa_pkg::S_L_RD: op = bsa_pkg::OP_L_RD;
      bsa_pkg::S_L_CHK: op = bsa_pkg::OP_L_CHK;
      bsa_pkg::S_L_BIT: op = bsa_pkg::OP_L_BIT;
      bsa_pkg::S_DONE: begin
        if (out_free) begin
          op = bsa_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      default: op = bsa_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/bsa_dp.sv -----
`timescale 1ns / 1ps

module bsa_dp #(
  parameter int MAP_WORDS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bsa_pkg::dp_op_t                    op,
  output bsa_pkg::dp_stat_t                  stat,
  input  bsa_pkg::in_t                       in_data,
  input  logic                               cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bsa_pkg::out_t                      out_data
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SW = AW + 6;
  localparam int CAP = MAP_WORDS * 64;
  localparam int CW = $clog2(CAP + 1);
  localparam int PW = SW + 16;

  // Configuration.
  logic [12:0] max_slots_r;
  logic [1:0]  page_kind_r;
  logic [15:0] slot_width_r;
  logic [63:0] base_r;
  logic [15:0] doff_r;

  // Page state.
  logic [CW-1:0]        in_use_r;
  logic                 full_r;
  logic [MAP_WORDS-1:0] uvld_r;
  logic [MAP_WORDS-1:0] vvld_r;
  logic                 uvld_q_r;
  logic                 vvld_q_r;

  // Per-request working registers.
  logic [3:0]    func_r;
  logic [15:0]   pos_r;
  logic          trans_r;
  logic [SW-1:0] slot_r;
  logic [2:0]    status_r;
  logic          wasf_r;
  logic [AW-1:0] cnt_r;
  logic [2:0]    bcnt_r;
  logic [63:0]   scan_r;
  logic [15:0]   rem_r;
  logic [15:0]   quo_r;
  logic [4:0]    dcnt_r;
  logic [PW-1:0] boff_r;
  logic [63:0]   laddr_r;
  logic [CW-1:0] last_r;
  bsa_pkg::out_t out_r;

  // RAM ports.
  logic          u_we, v_we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   u_wdata, v_wdata, u_rdata, v_rdata, uword, vword, bmask;

  logic [16:0] lim17, in_use17, pos17, quo17, ms17, cap17;
  logic        s_done, s_div, s_scan;
  logic [2:0]  s_status;
  logic        is_alloc, is_rel, bit_u;
  logic [16:0] r2, sw17;
  logic        div_ge;
  logic [15:0] rem_step;
  logic [7:0]  grp_free, grp_used;
  logic [2:0]  lo3, hi3;
  logic [SW-1:0] found_slot;
  logic [16:0] found17, last17;
  logic [15:0] slot16;
  logic [31:0] boff32;
  logic [16:0] used17, lastout17;

  assign ms17 = 17'(max_slots_r);
  assign cap17 = 17'(CAP);
  assign lim17 = (ms17 < cap17) ? ms17 : cap17;
  assign in_use17 = 17'(in_use_r);
  assign pos17 = 17'(pos_r);
  assign quo17 = 17'(quo_r);

  assign is_alloc = (func_r == bsa_pkg::F_ALLOC_FREE) || (func_r == bsa_pkg::F_ALLOC_AT);
  assign is_rel = (func_r == bsa_pkg::F_RELEASE) || (func_r == bsa_pkg::F_RELEASE_BYTE);

  // Words that were never written since reset or a clear read as zero.
  assign uword = uvld_q_r ? u_rdata : 64'd0;
  assign vword = vvld_q_r ? v_rdata : 64'd0;
  assign bmask = 64'd1 << slot_r[5:0];
  assign bit_u = uword[slot_r[5:0]];

  assign waddr = slot_r[SW-1:6];
  assign raddr = (op == bsa_pkg::OP_READ) ? slot_r[SW-1:6] : cnt_r;

  always_comb begin
    u_we = 1'b0;
    v_we = 1'b0;
    u_wdata = uword;
    v_wdata = vword;
    if (op == bsa_pkg::OP_RWAIT) begin
      if (is_alloc && !bit_u) begin
        u_we = 1'b1;
        u_wdata = uword | bmask;
        v_we = trans_r;
        v_wdata = vword | bmask;
      end else if (is_rel && bit_u) begin
        u_we = 1'b1;
        u_wdata = uword & ~bmask;
      end else if (func_r == bsa_pkg::F_SET_VER) begin
        v_we = 1'b1;
        v_wdata = vword | bmask;
      end else if (func_r == bsa_pkg::F_CLR_VER) begin
        v_we = 1'b1;
        v_wdata = vword & ~bmask;
      end
    end
  end

  bsa_ram #(.WIDTH(64), .DEPTH(MAP_WORDS)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(waddr), .wdata(u_wdata), .raddr(raddr), .rdata(u_rdata)
  );

  bsa_ram #(.WIDTH(64), .DEPTH(MAP_WORDS)) u_ver_ram (
    .clk(clk), .we(v_we), .waddr(waddr), .wdata(v_wdata), .raddr(raddr), .rdata(v_rdata)
  );

  // Decode of a new request.
  always_comb begin
    s_done = 1'b0;
    s_div = 1'b0;
    s_scan = 1'b0;
    s_status = bsa_pkg::ST_OK;
    case (func_r)
      bsa_pkg::F_ALLOC_FREE: begin
        if (in_use17 >= lim17) begin
          s_done = 1'b1;
          s_status = bsa_pkg::ST_FULL;
        end else if (page_kind_r != bsa_pkg::KIND_ENCODED) begin
          s_scan = 1'b1;
        end
      end
      bsa_pkg::F_ALLOC_AT, bsa_pkg::F_RELEASE, bsa_pkg::F_SET_VER, bsa_pkg::F_CLR_VER: begin
        if (pos17 >= lim17) begin
          s_done = 1'b1;
          s_status = bsa_pkg::ST_RANGE;
        end
      end
      bsa_pkg::F_RELEASE_BYTE: begin
        if (pos_r < doff_r || slot_width_r == 16'd0) begin
          s_done = 1'b1;
          s_status = bsa_pkg::ST_RANGE;
        end else begin
          s_div = 1'b1;
        end
      end
      bsa_pkg::F_SET_FULL, bsa_pkg::F_CLR_FULL, bsa_pkg::F_LAST, bsa_pkg::F_CLEAR: begin
        s_done = 1'b1;
      end
      default: begin
        s_done = 1'b1;
        s_status = bsa_pkg::ST_RANGE;
      end
    endcase
  end

  // One quotient bit per cycle, restoring form.
  assign sw17 = 17'(slot_width_r);
  assign r2 = {rem_r, quo_r[15]};
  assign div_ge = (r2 >= sw17);
  assign rem_step = div_ge ? 16'(r2 - sw17) : r2[15:0];

  assign grp_used = scan_r[{bcnt_r, 3'd0} +: 8];
  assign grp_free = ~grp_used;

  always_comb begin
    lo3 = 3'd0;
    hi3 = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_free[i]) lo3 = 3'(i);
    end
    for (int i = 0; i < 8; i++) begin
      if (grp_used[i]) hi3 = 3'(i);
    end
  end

  assign found_slot = {cnt_r, bcnt_r, lo3};
  assign found17 = 17'(found_slot);
  assign last17 = 17'({cnt_r, bcnt_r, hi3}) + 17'd1;

  always_comb begin
    stat = '0;
    stat.start_done = s_done;
    stat.start_div = s_div;
    stat.start_scan = s_scan;
    stat.div_last = (dcnt_r == 5'd1);
    stat.div_range = (quo17 >= lim17);
    stat.alloc_ok = is_alloc && !bit_u;
    stat.slot_over = (found17 >= lim17);
    case (op)
      bsa_pkg::OP_FS_CHK: begin
        stat.wd_hit = (~uword != 64'd0);
        stat.wd_end = (cnt_r == AW'(MAP_WORDS - 1));
      end
      bsa_pkg::OP_L_CHK: begin
        stat.wd_hit = (uword != 64'd0);
        stat.wd_end = (cnt_r == '0);
      end
      bsa_pkg::OP_FS_BIT: stat.grp_hit = (grp_free != 8'd0);
      bsa_pkg::OP_L_BIT: stat.grp_hit = (grp_used != 8'd0);
      default: stat.wd_hit = 1'b0;
    endcase
  end

  // Configuration and page state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slots_r <= 13'd4096;
      page_kind_r <= 2'd0;
      slot_width_r <= 16'd1;
      base_r <= 64'd0;
      doff_r <= 16'd0;
      in_use_r <= '0;
      full_r <= 1'b0;
      uvld_r <= '0;
      vvld_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bsa_pkg::CFG_MAX_SLOTS: max_slots_r <= cfg_data[12:0];
          bsa_pkg::CFG_PAGE_KIND: page_kind_r <= cfg_data[1:0];
          bsa_pkg::CFG_SLOT_WIDTH: slot_width_r <= cfg_data[15:0];
          bsa_pkg::CFG_BASE_ADDR: base_r <= cfg_data;
          bsa_pkg::CFG_DATA_OFFSET: doff_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (u_we) uvld_r[waddr] <= 1'b1;
      if (v_we) vvld_r[waddr] <= 1'b1;
      case (op)
        bsa_pkg::OP_START: begin
          case (func_r)
            bsa_pkg::F_SET_FULL: full_r <= 1'b1;
            bsa_pkg::F_CLR_FULL: full_r <= 1'b0;
            bsa_pkg::F_CLEAR: begin
              uvld_r <= '0;
              vvld_r <= '0;
              in_use_r <= '0;
            end
            default: ;
          endcase
        end
        bsa_pkg::OP_RWAIT: begin
          if (is_alloc && !bit_u) in_use_r <= in_use_r + CW'(1);
          else if (is_rel && bit_u) in_use_r <= in_use_r - CW'(1);
        end
        default: ;
      endcase
    end
  end

  assign slot16 = 16'(slot_r);
  assign boff32 = 32'(boff_r);
  assign used17 = 17'(in_use_r);
  assign lastout17 = 17'(last_r);

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    uvld_q_r <= uvld_r[raddr];
    vvld_q_r <= vvld_r[raddr];
    case (op)
      bsa_pkg::OP_LOAD: begin
        func_r <= in_data.func;
        pos_r <= in_data.position;
        trans_r <= in_data.transactional;
        status_r <= bsa_pkg::ST_OK;
        slot_r <= '0;
        wasf_r <= 1'b0;
        laddr_r <= 64'd0;
        boff_r <= '0;
      end
      bsa_pkg::OP_START: begin
        status_r <= s_status;
        cnt_r <= '0;
        if (is_rel) wasf_r <= full_r;
        if (func_r == bsa_pkg::F_ALLOC_FREE) slot_r <= in_use_r[SW-1:0];
        else slot_r <= pos_r[SW-1:0];
        if (s_done) slot_r <= '0;
        quo_r <= pos_r - doff_r;
        rem_r <= 16'd0;
        dcnt_r <= 5'd16;
      end
      bsa_pkg::OP_DIV: begin
        rem_r <= rem_step;
        quo_r <= {quo_r[14:0], div_ge};
        dcnt_r <= dcnt_r - 5'd1;
      end
      bsa_pkg::OP_POSTDIV: begin
        if (quo17 >= lim17) begin
          status_r <= bsa_pkg::ST_RANGE;
          slot_r <= '0;
        end else begin
          slot_r <= quo_r[SW-1:0];
        end
      end
      bsa_pkg::OP_RWAIT: begin
        if (is_alloc && bit_u) status_r <= bsa_pkg::ST_USED;
        else if (is_rel && !bit_u) status_r <= bsa_pkg::ST_NOT_USED;
      end
      bsa_pkg::OP_FS_CHK: begin
        scan_r <= uword;
        bcnt_r <= 3'd0;
        if (~uword == 64'd0) begin
          if (cnt_r == AW'(MAP_WORDS - 1)) begin
            status_r <= bsa_pkg::ST_FULL;
            slot_r <= '0;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
      end
      bsa_pkg::OP_FS_BIT: begin
        if (grp_free != 8'd0) begin
          if (found17 >= lim17) begin
            status_r <= bsa_pkg::ST_FULL;
            slot_r <= '0;
          end else begin
            slot_r <= found_slot;
          end
        end else begin
          bcnt_r <= bcnt_r + 3'd1;
        end
      end
      bsa_pkg::OP_MUL: boff_r <= PW'(slot_r) * PW'(slot_width_r);
      bsa_pkg::OP_ADDR: begin
        if (page_kind_r == bsa_pkg::KIND_VARIABLE) begin
          laddr_r <= base_r + 64'(doff_r) + 64'(boff_r);
        end else begin
          laddr_r <= base_r + 64'(slot_r);
        end
      end
      bsa_pkg::OP_L_INIT: begin
        cnt_r <= AW'(MAP_WORDS - 1);
        last_r <= '0;
      end
      bsa_pkg::OP_L_CHK: begin
        scan_r <= uword;
        bcnt_r <= 3'd7;
        if (uword == 64'd0 && cnt_r != '0) cnt_r <= cnt_r - AW'(1);
      end
      bsa_pkg::OP_L_BIT: begin
        if (grp_used != 8'd0) last_r <= last17[CW-1:0];
        else bcnt_r <= bcnt_r - 3'd1;
      end
      bsa_pkg::OP_OUT: begin
        out_r.status <= status_r;
        out_r.slot_index <= slot16[11:0];
        out_r.logical_address <= laddr_r;
        out_r.slot_byte_offset <= boff32[27:0];
        out_r.full_seen <= wasf_r;
        out_r.last_slot <= lastout17[12:0];
        out_r.used_count <= used17[12:0];
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule
